// ===== src/rotate_vector_about_axis_defines.svh =====
// assertion macros shared by the checker
`ifndef ROTATE_VECTOR_ABOUT_AXIS_DEFINES_SVH
`define ROTATE_VECTOR_ABOUT_AXIS_DEFINES_SVH

// condition holds at every edge out of reset
`define RVA_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define RVA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RVA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rva_pkg.sv =====
package rva_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int TABLE_LEN         = 30;

	// cordic datapath width, q2.30 plus headroom
	localparam int CDW = 34;
	localparam int VW  = 32;
	localparam int AW  = 16;
	// dot and cross products after rounding to q20.16
	localparam int PW  = 36;

	localparam logic signed [CDW-1:0] GAIN_Q30 = 34'sd652032874;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [TABLE_LEN-1:0][31:0] ATAN_TURN32 = {
		32'd1,        32'd3,        32'd5,        32'd10,       32'd20,
		32'd41,       32'd81,       32'd163,      32'd326,      32'd652,
		32'd1304,     32'd2608,     32'd5215,     32'd10430,    32'd20861,
		32'd41722,    32'd83443,    32'd166886,   32'd333772,   32'd667544,
		32'd1335087,  32'd2670163,  32'd5340245,  32'd10679838, 32'd21354465,
		32'd42667331, 32'd85004756, 32'd167458907, 32'd316933406, 32'd536870912
	};

	typedef struct packed {
		logic                  valid;
		logic                  flip;
		logic signed [CDW-1:0] x;
		logic signed [CDW-1:0] y;
		logic signed [CDW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic [2:0][VW-1:0] v;
		logic [2:0][AW-1:0] a;
		logic [PW-1:0]      dot;
		logic [2:0][PW-1:0] cr;
	} vec_t;

	// round half up and shift right arithmetically
	function automatic logic signed [63:0] rnd64(input logic signed [63:0] val, input int sh);
		logic signed [63:0] half;
		half = 64'sd1 <<< (sh - 1);
		return (val + half) >>> sh;
	endfunction

endpackage

// ===== src/rotate_vector_about_axis.sv =====
// path from input transfer to output valid: input register, CORDIC cells, stages m1 to m4, output register
// throughput: one vector per cycle while the output is not stalled, set by the chain of CORDIC cells (one per stage)
// a stalled output freezes the whole pipeline; no bubbles are removed
// reset clears only the valid bits of the pipeline and the output register
module rotate_vector_about_axis import rva_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z
	output logic [95:0]  m_tdata,
	// saturated
	output logic [0:0]   m_tuser
);

	localparam int CW  = FRAC_BITS + 3;
	localparam int SH  = 30 - FRAC_BITS;
	localparam int DLY = CORDIC_STAGES - 2;
	localparam int TW  = 40;
	localparam int QW  = 41;
	localparam int AQW = AW + QW;
	localparam int SW  = 46;

	logic en;
	logic m_tvalid_q;

	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = m_tvalid_q;

	// input register
	logic               valid_s1;
	logic [2:0][VW-1:0] v_s1;
	logic [2:0][AW-1:0] a_s1;
	logic [15:0]        turn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				v_s1[k] <= s_tdata[k*VW +: VW];
				a_s1[k] <= s_tdata[3*VW + k*AW +: AW];
			end
			turn_s1 <= s_tdata[159:144];
		end
	end

	// quadrant fold and cordic chain
	cordic_t cord [CORDIC_STAGES+1];
	logic    flip_w;

	always_comb begin
		flip_w        = turn_s1[15] ^ turn_s1[14];
		cord[0].valid = valid_s1;
		cord[0].flip  = flip_w;
		cord[0].x     = GAIN_Q30;
		cord[0].y     = '0;
		cord[0].z     = CDW'($signed({turn_s1[15] ^ flip_w, turn_s1[14:0], 16'd0}));
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		rva_cordic_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (cord[i]),
			.dout   (cord[i+1])
		);
	end

	// vector side: products, then delay to meet the cordic output
	vec_t vf;
	vec_t dl_q [DLY];

	rva_vec_front u_front (
		.clk  (clk),
		.en   (en),
		.v    (v_s1),
		.a    (a_s1),
		.dout (vf)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dl_q[0] <= vf;
			for (int k = 1; k < DLY; k++) begin
				dl_q[k] <= dl_q[k-1];
			end
		end
	end

	// m1: round cos and sin, undo the fold
	cordic_t            cl;
	logic signed [63:0] xr_w, yr_w;
	logic signed [CW-1:0] c_w, s_w;
	logic               valid_m1;
	logic signed [CW-1:0] c_m1, s_m1;
	logic signed [CW:0] omc_m1;
	vec_t               vd_m1;

	assign cl = cord[CORDIC_STAGES];

	always_comb begin
		xr_w = rnd64(64'(cl.x), SH);
		yr_w = rnd64(64'(cl.y), SH);
		c_w  = cl.flip ? -xr_w[CW-1:0] : xr_w[CW-1:0];
		s_w  = cl.flip ? -yr_w[CW-1:0] : yr_w[CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_m1   <= c_w;
			s_m1   <= s_w;
			omc_m1 <= (CW+1)'(1 << FRAC_BITS) - (CW+1)'(c_w);
			vd_m1  <= dl_q[DLY-1];
		end
	end

	// m2: products with cos, sin and one minus cos
	logic signed [VW+CW-1:0]   vc_m2 [3];
	logic signed [PW+CW-1:0]   cs_m2 [3];
	logic signed [PW+CW:0]     qq_m2;
	logic [2:0][AW-1:0]        a_m2;
	logic                      valid_m2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				vc_m2[k] <= $signed(vd_m1.v[k]) * c_m1;
				cs_m2[k] <= $signed(vd_m1.cr[k]) * s_m1;
			end
			qq_m2 <= $signed(vd_m1.dot) * omc_m1;
			a_m2  <= vd_m1.a;
		end
	end

	// m3: round the three kinds of product
	logic signed [TW-1:0] t1_m3 [3];
	logic signed [TW-1:0] t3_m3 [3];
	logic signed [QW-1:0] q2_m3;
	logic [2:0][AW-1:0]   a_m3;
	logic signed [63:0]   q2_w;
	logic signed [63:0]   t1_w [3];
	logic signed [63:0]   t3_w [3];
	logic                 valid_m3;

	always_comb begin
		q2_w = rnd64(64'(qq_m2), FRAC_BITS);
		for (int k = 0; k < 3; k++) begin
			t1_w[k] = rnd64(64'(vc_m2[k]), FRAC_BITS);
			t3_w[k] = rnd64(64'(cs_m2[k]), FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q2_m3 <= q2_w[QW-1:0];
			for (int k = 0; k < 3; k++) begin
				t1_m3[k] <= t1_w[k][TW-1:0];
				t3_m3[k] <= t3_w[k][TW-1:0];
			end
			a_m3 <= a_m2;
		end
	end

	// m4: axis times scaled projection, and sum of the cos and sin terms
	logic signed [AQW-1:0] aq_m4 [3];
	logic signed [TW:0]    t13_m4 [3];
	logic                  valid_m4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				aq_m4[k]  <= $signed(a_m3[k]) * q2_m3;
				t13_m4[k] <= (TW+1)'(t1_m3[k]) + (TW+1)'(t3_m3[k]);
			end
		end
	end

	// m5: final sum and saturation into the output register
	logic signed [63:0]   t2_w [3];
	logic signed [SW-1:0] sum_w [3];
	logic [2:0][VW-1:0]   res_w;
	logic [2:0]           clip_w;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t2_w[k]  = rnd64(64'(aq_m4[k]), 14);
			sum_w[k] = SW'(t13_m4[k]) + t2_w[k][SW-1:0];
			if (sum_w[k] > SW'(64'sd2147483647)) begin
				res_w[k]  = 32'h7FFF_FFFF;
				clip_w[k] = 1'b1;
			end else if (sum_w[k] < SW'(-64'sd2147483648)) begin
				res_w[k]  = 32'h8000_0000;
				clip_w[k] = 1'b1;
			end else begin
				res_w[k]  = sum_w[k][VW-1:0];
				clip_w[k] = 1'b0;
			end
		end
	end

	// valid bits of the back-end stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m1   <= 1'b0;
			valid_m2   <= 1'b0;
			valid_m3   <= 1'b0;
			valid_m4   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			valid_m1   <= cl.valid;
			valid_m2   <= valid_m1;
			valid_m3   <= valid_m2;
			valid_m4   <= valid_m3;
			m_tvalid_q <= valid_m4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= res_w;
			m_tuser <= |clip_w;
		end
	end

endmodule

// ===== src/rva_cordic_cell.sv =====
module rva_cordic_cell import rva_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  cordic_t din,
	output cordic_t dout
);

	localparam logic signed [CDW-1:0] ANG = CDW'(ATAN_TURN32[IDX]);

	logic signed [CDW-1:0] dx, dy;
	cordic_t nxt;
	logic                  valid_q;
	logic                  flip_q;
	logic signed [CDW-1:0] x_q, y_q, z_q;

	// one micro-rotation toward zero residual angle
	always_comb begin
		dx = din.y >>> IDX;
		dy = din.x >>> IDX;
		nxt = din;
		if (!din.z[CDW-1]) begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - ANG;
		end else begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flip_q <= nxt.flip;
			x_q    <= nxt.x;
			y_q    <= nxt.y;
			z_q    <= nxt.z;
		end
	end

	assign dout = '{valid: valid_q, flip: flip_q, x: x_q, y: y_q, z: z_q};

endmodule

// ===== src/rva_vec_front.sv =====
module rva_vec_front import rva_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [2:0][VW-1:0] v,
	input  logic [2:0][AW-1:0] a,
	output vec_t               dout
);

	logic signed [VW+AW-1:0] dp_s1 [3];
	logic signed [VW+AW-1:0] cp_s1 [6];
	logic [2:0][VW-1:0]      v_s1;
	logic [2:0][AW-1:0]      a_s1;
	logic signed [63:0]      dot_w;
	logic signed [63:0]      cr_w [3];

	// stage 1: all partial products of dot and cross
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dp_s1[k] <= $signed(v[k]) * $signed(a[k]);
			end
			cp_s1[0] <= $signed(v[1]) * $signed(a[2]);
			cp_s1[1] <= $signed(v[2]) * $signed(a[1]);
			cp_s1[2] <= $signed(v[2]) * $signed(a[0]);
			cp_s1[3] <= $signed(v[0]) * $signed(a[2]);
			cp_s1[4] <= $signed(v[0]) * $signed(a[1]);
			cp_s1[5] <= $signed(v[1]) * $signed(a[0]);
			v_s1 <= v;
			a_s1 <= a;
		end
	end

	// stage 2: sums and rounding from q.30 to q20.16
	always_comb begin
		dot_w = rnd64(64'(dp_s1[0]) + 64'(dp_s1[1]) + 64'(dp_s1[2]), 14);
		for (int k = 0; k < 3; k++) begin
			cr_w[k] = rnd64(64'(cp_s1[2*k]) - 64'(cp_s1[2*k+1]), 14);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.v   <= v_s1;
			dout.a   <= a_s1;
			dout.dot <= dot_w[PW-1:0];
			for (int k = 0; k < 3; k++) begin
				dout.cr[k] <= cr_w[k][PW-1:0];
			end
		end
	end

endmodule

// ===== src/rva_checker.sv =====
`include "rotate_vector_about_axis_defines.svh"

module rva_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [95:0]  m_tdata,
	input logic [0:0]   m_tuser
);

	logic [2:0] at_limit;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			at_limit[k] = (m_tdata[k*32 +: 32] == 32'h7FFF_FFFF) ||
				(m_tdata[k*32 +: 32] == 32'h8000_0000);
		end
	end

	// a held result keeps its payload
	`RVA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	// input side stalls only when the output register is full and blocked
	`RVA_ASSERT_ALWAYS(a_ready, s_tready == (!m_tvalid || m_tready), "ready does not follow output stall")
	// a clip flag needs a component at a rail
	`RVA_ASSERT_IMP(a_sat, m_tvalid && m_tuser[0], at_limit != 3'b000, "saturated flag without clipped component")

endmodule

bind rotate_vector_about_axis rva_checker u_rva_checker (.*);
